// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/i2cbm_pkg.sv -----
package i2cbm_pkg;

	// operation codes
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_START    = 3'd1;
	localparam logic [2:0] OP_STOP     = 3'd2;
	localparam logic [2:0] OP_WRITE    = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;
	localparam logic [2:0] OP_ACK      = 3'd5;
	localparam logic [2:0] OP_NACK     = 3'd6;
	localparam logic [2:0] OP_WAIT_ACK = 3'd7;

	// idle shares the tick code
	localparam logic [2:0] CMD_IDLE = 3'd0;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_ACK_TIMEOUT = 1'b0;  // word index of ack_timeout
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic       is_tick;
		logic [2:0] op;
		logic [7:0] data;
		logic       sda;
	} item_t;

endpackage

// ----- hdl/i2cbm_if.sv -----
interface i2cbm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] write_data;
	logic       sda_in;

	modport source (output valid, operation, write_data, sda_in, input ready);
	modport sink (input valid, operation, write_data, sda_in, output ready);
endinterface

interface i2cbm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       ack_error;

	modport source (output valid, scl_level, sda_level, busy_res, done_res, read_data,
		ack_error, input ready);
	modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_data,
		ack_error, output ready);
endinterface

// ----- hdl/i2cbm_front.sv -----
`include "assert_macros.svh"

module i2cbm_front #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	i2cbm_cmd_if.sink          cmd,
	output i2cbm_pkg::item_t   item,
	output logic               item_valid,
	input  logic               pop
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_C = PTR_W'(DEPTH - 1);

	i2cbm_pkg::item_t        queue_q [DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [CNT_W-1:0]        count_q;
	logic                    push;
	i2cbm_pkg::item_t        classified;

	assign cmd.ready = (count_q != DEPTH_C);
	assign push = cmd.valid && cmd.ready;

	always_comb begin
		classified.is_tick = (cmd.operation == i2cbm_pkg::OP_TICK);
		classified.op      = cmd.operation;
		classified.data    = cmd.write_data;
		classified.sda     = cmd.sda_in;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign item_valid = (count_q != '0);
	assign item = queue_q[rd_ptr_q];

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= DEPTH_C, "queue count over depth")
	`ASSERT_NEXT(a_pop_nonempty, clk, arst_n, pop, $past(count_q) != '0, "pop from empty queue")
	`ASSERT_NEXT(a_count_inc, clk, arst_n, push && !pop, count_q == CNT_W'($past(count_q) + 1'b1),
		"queue count missed a push")
endmodule

// ----- hdl/i2cbm_engine.sv -----
`include "assert_macros.svh"

module i2cbm_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       ack_timeout,
	input  i2cbm_pkg::item_t item,
	input  logic             item_valid,
	output logic             pop,
	i2cbm_res_if.source      res
);
	logic [2:0] cmd_q, n_cmd;
	logic [2:0] phase_q, n_phase;
	logic [3:0] bits_q, n_bits;
	logic [7:0] shift_q, n_shift;
	logic [7:0] wait_q, n_wait;
	logic [7:0] held_q, n_held;
	logic       scl_q, n_scl;
	logic       sda_q, n_sda;
	logic       err_q, n_err;
	logic       done_q, n_done;
	logic       vld_q;
	logic [3:0] bits_inc;
	logic [7:0] shift_in;

	// result lines come straight from the state; it only moves on a pop
	assign pop = item_valid && (!vld_q || res.ready);

	assign bits_inc = 4'(bits_q + 4'd1);
	assign shift_in = {shift_q[6:0], item.sda};

	always_comb begin
		n_cmd   = cmd_q;
		n_phase = phase_q;
		n_bits  = bits_q;
		n_shift = shift_q;
		n_wait  = wait_q;
		n_held  = held_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_err   = err_q;
		n_done  = 1'b0;
		if (!item.is_tick) begin
			if (cmd_q == i2cbm_pkg::CMD_IDLE) begin
				n_cmd   = item.op;
				n_phase = 3'd0;
				n_err   = 1'b0;
				case (item.op)
					i2cbm_pkg::OP_START, i2cbm_pkg::OP_STOP: begin
						n_sda = 1'b0;
					end
					i2cbm_pkg::OP_WRITE: begin
						n_shift = item.data;
						n_bits  = 4'd0;
						n_sda   = item.data[7];
					end
					i2cbm_pkg::OP_READ: begin
						n_shift = 8'd0;
						n_bits  = 4'd0;
						n_scl   = 1'b0;
						n_sda   = 1'b1;
					end
					i2cbm_pkg::OP_ACK: begin
						n_scl = 1'b0;
						n_sda = 1'b0;
					end
					i2cbm_pkg::OP_NACK: begin
						n_scl = 1'b0;
						n_sda = 1'b1;
					end
					default: begin
						n_wait = 8'd0;
						n_sda  = 1'b1;
					end
				endcase
			end
		end else if (cmd_q != i2cbm_pkg::CMD_IDLE) begin
			case (cmd_q)
				i2cbm_pkg::OP_START: begin
					n_phase = 3'(phase_q + 3'd1);
					case (phase_q)
						3'd0:    n_scl = 1'b1;
						3'd1:    n_sda = 1'b1;
						3'd2:    n_sda = 1'b0;
						3'd3:    n_scl = 1'b0;
						default: n_done = 1'b1;
					endcase
				end
				i2cbm_pkg::OP_STOP: begin
					n_phase = 3'(phase_q + 3'd1);
					case (phase_q)
						3'd0:    n_scl = 1'b1;
						3'd1:    n_sda = 1'b1;
						default: n_done = 1'b1;
					endcase
				end
				i2cbm_pkg::OP_WRITE: begin
					case (phase_q)
						3'd0: begin
							n_scl   = 1'b1;
							n_phase = 3'd1;
						end
						3'd1: begin
							n_scl  = 1'b0;
							n_bits = bits_inc;
							if (bits_inc < i2cbm_pkg::BITS_PER_BYTE) begin
								n_shift = {shift_q[6:0], 1'b0};
								n_sda   = shift_q[6];
								n_phase = 3'd0;
							end else begin
								// acknowledge clock with SDA released, not sampled
								n_sda   = 1'b1;
								n_phase = 3'd2;
							end
						end
						3'd2: begin
							n_scl   = 1'b1;
							n_phase = 3'd3;
						end
						default: begin
							n_scl  = 1'b0;
							n_done = 1'b1;
						end
					endcase
				end
				i2cbm_pkg::OP_READ: begin
					case (phase_q)
						3'd0: begin
							n_scl   = 1'b1;
							n_phase = 3'd1;
						end
						3'd1: begin
							n_shift = shift_in;
							n_bits  = bits_inc;
							n_scl   = 1'b0;
							if (bits_inc < i2cbm_pkg::BITS_PER_BYTE) begin
								n_phase = 3'd0;
							end else begin
								n_sda   = 1'b0;
								n_phase = 3'd2;
							end
						end
						3'd2: begin
							n_scl   = 1'b1;
							n_phase = 3'd3;
						end
						3'd3: begin
							n_scl   = 1'b0;
							n_phase = 3'd4;
						end
						default: begin
							n_sda  = 1'b1;
							n_held = shift_q;
							n_done = 1'b1;
						end
					endcase
				end
				i2cbm_pkg::OP_ACK: begin
					n_phase = 3'(phase_q + 3'd1);
					case (phase_q)
						3'd0: n_scl = 1'b1;
						3'd1: n_scl = 1'b0;
						default: begin
							n_sda  = 1'b1;
							n_done = 1'b1;
						end
					endcase
				end
				i2cbm_pkg::OP_NACK: begin
					n_phase = 3'(phase_q + 3'd1);
					if (phase_q == 3'd0) begin
						n_scl = 1'b1;
					end else begin
						n_scl  = 1'b0;
						n_done = 1'b1;
					end
				end
				default: begin
					if (phase_q == 3'd0) begin
						n_scl   = 1'b1;
						n_phase = 3'd1;
					end else if (!item.sda) begin
						n_scl  = 1'b0;
						n_done = 1'b1;
					end else if (wait_q >= ack_timeout) begin
						// timed out: fall into a stop with SCL still high
						n_err   = 1'b1;
						n_cmd   = i2cbm_pkg::OP_STOP;
						n_phase = 3'd0;
						n_sda   = 1'b0;
					end else begin
						n_wait = 8'(wait_q + 8'd1);
					end
				end
			endcase
			if (n_done) begin
				n_cmd   = i2cbm_pkg::CMD_IDLE;
				n_phase = 3'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cbm_pkg::CMD_IDLE;
			phase_q <= 3'd0;
			bits_q  <= 4'd0;
			shift_q <= 8'd0;
			wait_q  <= 8'd0;
			held_q  <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			err_q   <= 1'b0;
			done_q  <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			if (pop) begin
				cmd_q   <= n_cmd;
				phase_q <= n_phase;
				bits_q  <= n_bits;
				shift_q <= n_shift;
				wait_q  <= n_wait;
				held_q  <= n_held;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
				err_q   <= n_err;
				done_q  <= n_done;
				vld_q   <= 1'b1;
			end else if (res.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign res.valid     = vld_q;
	assign res.scl_level = scl_q;
	assign res.sda_level = sda_q;
	assign res.busy_res  = (cmd_q != i2cbm_pkg::CMD_IDLE);
	assign res.done_res  = done_q;
	assign res.read_data = held_q;
	assign res.ack_error = err_q;

	`ASSERT_ALWAYS(a_idle_phase, clk, arst_n, cmd_q != i2cbm_pkg::CMD_IDLE || phase_q == 3'd0,
		"idle engine with nonzero phase")
	`ASSERT_ALWAYS(a_err_cmd, clk, arst_n,
		!err_q || cmd_q == i2cbm_pkg::OP_STOP || cmd_q == i2cbm_pkg::CMD_IDLE,
		"ack error outside stop or idle")
	`ASSERT_ALWAYS(a_done_idle, clk, arst_n, !done_q || cmd_q == i2cbm_pkg::CMD_IDLE,
		"done reported while still busy")
endmodule

// ----- hdl/i2c_bit_level_master_core.sv -----
// Bit-level I2C master. Each transaction on cmd is a command (start, stop, write byte,
// read byte, ack, nack, wait-for-ack) or a tick that steps the current command; every
// transaction yields exactly one result transaction on res with the line levels, busy,
// done, the last read byte and the ack error flag. Throughput is one transaction per
// clock while res is taken: the command queue feeds an engine that takes one item per
// step; a held result stalls the engine, and cmd too once the queue is full. Results
// come from the engine state registers, after the command queue. ack_timeout sits at
// APB byte address 0 and should only be written while the engine is idle.
module i2c_bit_level_master_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [i2cbm_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [i2cbm_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [i2cbm_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                 pready,
	i2cbm_cmd_if.sink                            cmd,
	i2cbm_res_if.source                          res
);
	logic [7:0]       ack_timeout_q;
	i2cbm_pkg::item_t item;
	logic             item_valid;
	logic             pop;
	logic             reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == i2cbm_pkg::REG_ACK_TIMEOUT);
	assign prdata  = reg_hit ? {{(i2cbm_pkg::APB_DATA_W - 8){1'b0}}, ack_timeout_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= i2cbm_pkg::ACK_TIMEOUT_RST;
		end else if (psel && penable && pwrite && reg_hit) begin
			ack_timeout_q <= pwdata[7:0];
		end
	end

	i2cbm_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item       (item),
		.item_valid (item_valid),
		.pop        (pop)
	);

	i2cbm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.ack_timeout (ack_timeout_q),
		.item        (item),
		.item_valid  (item_valid),
		.pop         (pop),
		.res         (res)
	);
endmodule

// ----- test/tb_i2c_bit_level_master_core.sv -----
`timescale 1ns / 1ps

module tb_i2c_bit_level_master_core;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 200;
	localparam int PHASE_ITEMS  = 50;
	localparam int NEVER_LOW    = -1;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rdata;
		logic       err;
	} line_state_t;

	logic                             clk;
	logic                             arst_n;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [i2cbm_pkg::APB_ADDR_W-1:0] paddr;
	logic [i2cbm_pkg::APB_DATA_W-1:0] pwdata;
	logic [i2cbm_pkg::APB_DATA_W-1:0] prdata;
	logic                             pready;

	i2cbm_cmd_if cmd_bus ();
	i2cbm_res_if res_bus ();

	i2c_bit_level_master_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_bus.sink),
		.res     (res_bus.source)
	);

	// bus engine mirror
	logic [2:0] mdl_cmd;
	logic [2:0] mdl_phase;
	logic [3:0] mdl_bits;
	logic [7:0] mdl_shift;
	logic [7:0] mdl_wait;
	logic       mdl_scl;
	logic       mdl_sda;
	logic       mdl_err;
	logic [7:0] mdl_read;
	logic [7:0] mdl_timeout;

	line_state_t line_expect_q[$];

	int errors;
	int live_items;
	int cycle_count;
	int src_idle_pct;
	int rsp_idle_pct;
	int noise_pct;
	int hold_requests;
	int holds_served;
	int hold_left;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res_bus.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			res_bus.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end else begin
			res_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	always @(posedge clk) begin
		line_state_t exp_line;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (line_expect_q.size() == 0) begin
				$error("result transaction with no expectation pending");
				errors++;
			end else begin
				exp_line = line_expect_q.pop_front();
				if (res_bus.scl_level !== exp_line.scl) begin
					$error("scl_level: expected %0d, got %0d", exp_line.scl, res_bus.scl_level);
					errors++;
				end
				if (res_bus.sda_level !== exp_line.sda) begin
					$error("sda_level: expected %0d, got %0d", exp_line.sda, res_bus.sda_level);
					errors++;
				end
				if (res_bus.busy_res !== exp_line.busy) begin
					$error("busy_res: expected %0d, got %0d", exp_line.busy, res_bus.busy_res);
					errors++;
				end
				if (res_bus.done_res !== exp_line.done) begin
					$error("done_res: expected %0d, got %0d", exp_line.done, res_bus.done_res);
					errors++;
				end
				if (res_bus.read_data !== exp_line.rdata) begin
					$error("read_data: expected 0x%02h, got 0x%02h", exp_line.rdata,
						res_bus.read_data);
					errors++;
				end
				if (res_bus.ack_error !== exp_line.err) begin
					$error("ack_error: expected %0d, got %0d", exp_line.err, res_bus.ack_error);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic predict_step(input logic [2:0] op, input logic [7:0] data, input logic sda);
		line_state_t nxt;
		logic        fin;
		logic [2:0]  p;
		fin = 1'b0;
		p = mdl_phase;
		if (op != i2cbm_pkg::OP_TICK) begin
			if (mdl_cmd == i2cbm_pkg::CMD_IDLE) begin
				live_items++;
				mdl_cmd = op;
				mdl_phase = 3'd0;
				mdl_err = 1'b0;
				case (op)
					i2cbm_pkg::OP_START, i2cbm_pkg::OP_STOP: mdl_sda = 1'b0;
					i2cbm_pkg::OP_WRITE: begin
						mdl_shift = data;
						mdl_bits = 4'd0;
						mdl_sda = data[7];
					end
					i2cbm_pkg::OP_READ: begin
						mdl_shift = 8'd0;
						mdl_bits = 4'd0;
						mdl_scl = 1'b0;
						mdl_sda = 1'b1;
					end
					i2cbm_pkg::OP_ACK: begin
						mdl_scl = 1'b0;
						mdl_sda = 1'b0;
					end
					i2cbm_pkg::OP_NACK: begin
						mdl_scl = 1'b0;
						mdl_sda = 1'b1;
					end
					default: begin
						mdl_wait = 8'd0;
						mdl_sda = 1'b1;
					end
				endcase
			end
		end else if (mdl_cmd != i2cbm_pkg::CMD_IDLE) begin
			live_items++;
			case (mdl_cmd)
				i2cbm_pkg::OP_START: begin
					case (p)
						3'd0: mdl_scl = 1'b1;
						3'd1: mdl_sda = 1'b1;
						3'd2: mdl_sda = 1'b0;
						3'd3: mdl_scl = 1'b0;
						default: fin = 1'b1;
					endcase
					if (!fin)
						mdl_phase = mdl_phase + 3'd1;
				end
				i2cbm_pkg::OP_STOP: begin
					case (p)
						3'd0: mdl_scl = 1'b1;
						3'd1: mdl_sda = 1'b1;
						default: fin = 1'b1;
					endcase
					if (!fin)
						mdl_phase = mdl_phase + 3'd1;
				end
				i2cbm_pkg::OP_WRITE: begin
					if (p == 3'd0) begin
						mdl_scl = 1'b1;
						mdl_phase = 3'd1;
					end else if (p == 3'd1) begin
						mdl_scl = 1'b0;
						mdl_bits = mdl_bits + 4'd1;
						if (mdl_bits < i2cbm_pkg::BITS_PER_BYTE) begin
							mdl_shift = {mdl_shift[6:0], 1'b0};
							mdl_sda = mdl_shift[7];
							mdl_phase = 3'd0;
						end else begin
							mdl_sda = 1'b1;
							mdl_phase = 3'd2;
						end
					end else if (p == 3'd2) begin
						mdl_scl = 1'b1;
						mdl_phase = 3'd3;
					end else begin
						mdl_scl = 1'b0;
						fin = 1'b1;
					end
				end
				i2cbm_pkg::OP_READ: begin
					if (p == 3'd0) begin
						mdl_scl = 1'b1;
						mdl_phase = 3'd1;
					end else if (p == 3'd1) begin
						mdl_shift = {mdl_shift[6:0], sda};
						mdl_bits = mdl_bits + 4'd1;
						mdl_scl = 1'b0;
						if (mdl_bits < i2cbm_pkg::BITS_PER_BYTE) begin
							mdl_phase = 3'd0;
						end else begin
							mdl_sda = 1'b0;
							mdl_phase = 3'd2;
						end
					end else if (p == 3'd2) begin
						mdl_scl = 1'b1;
						mdl_phase = 3'd3;
					end else if (p == 3'd3) begin
						mdl_scl = 1'b0;
						mdl_phase = 3'd4;
					end else begin
						mdl_sda = 1'b1;
						mdl_read = mdl_shift;
						fin = 1'b1;
					end
				end
				i2cbm_pkg::OP_ACK: begin
					case (p)
						3'd0: mdl_scl = 1'b1;
						3'd1: mdl_scl = 1'b0;
						default: begin
							mdl_sda = 1'b1;
							fin = 1'b1;
						end
					endcase
					if (!fin)
						mdl_phase = mdl_phase + 3'd1;
				end
				i2cbm_pkg::OP_NACK: begin
					if (p == 3'd0) begin
						mdl_scl = 1'b1;
						mdl_phase = mdl_phase + 3'd1;
					end else begin
						mdl_scl = 1'b0;
						fin = 1'b1;
					end
				end
				default: begin
					if (p == 3'd0) begin
						mdl_scl = 1'b1;
						mdl_phase = 3'd1;
					end else if (!sda) begin
						mdl_scl = 1'b0;
						fin = 1'b1;
					end else if (mdl_wait >= mdl_timeout) begin
						// timed out: fall into a stop with SDA pulled low
						mdl_err = 1'b1;
						mdl_cmd = i2cbm_pkg::OP_STOP;
						mdl_phase = 3'd0;
						mdl_sda = 1'b0;
					end else begin
						mdl_wait = mdl_wait + 8'd1;
					end
				end
			endcase
			if (fin) begin
				mdl_cmd = i2cbm_pkg::CMD_IDLE;
				mdl_phase = 3'd0;
			end
		end
		nxt.scl = mdl_scl;
		nxt.sda = mdl_sda;
		nxt.busy = (mdl_cmd != i2cbm_pkg::CMD_IDLE);
		nxt.done = fin;
		nxt.rdata = mdl_read;
		nxt.err = mdl_err;
		line_expect_q.push_back(nxt);
	endtask

	task automatic send_item(input logic [2:0] op, input logic [7:0] data, input logic sda);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.operation <= op;
		cmd_bus.write_data <= data;
		cmd_bus.sda_in <= sda;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		predict_step(op, data, sda);
	endtask

	// one command plus the ticks, with random noise items, that carry it to completion
	task automatic run_command(input logic [2:0] op, input logic [7:0] data,
		input logic [7:0] sda_pat, input int ack_low_at);
		int   n;
		logic s;
		send_item(op, data, 1'($urandom_range(1)));
		n = 0;
		while (mdl_cmd != i2cbm_pkg::CMD_IDLE) begin
			if ($urandom_range(99) < noise_pct) begin
				send_item(3'($urandom_range(1, 7)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
			end else begin
				if (mdl_cmd == i2cbm_pkg::OP_READ)
					s = (mdl_bits < i2cbm_pkg::BITS_PER_BYTE) ? sda_pat[3'd7 - mdl_bits[2:0]]
						: 1'($urandom_range(1));
				else if (mdl_cmd == i2cbm_pkg::OP_WAIT_ACK)
					s = (ack_low_at != NEVER_LOW && n >= ack_low_at) ? 1'b0 : 1'b1;
				else
					s = 1'($urandom_range(1));
				send_item(i2cbm_pkg::OP_TICK, 8'($urandom_range(255)), s);
				n++;
			end
		end
	endtask

	task automatic wait_results_drained();
		// the last transaction was already taken; stop offering it
		cmd_bus.valid <= 1'b0;
		while (line_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_ack_timeout(input logic [7:0] value);
		wait_results_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {i2cbm_pkg::REG_ACK_TIMEOUT, 2'b00};
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mdl_timeout = value;
	endtask

	task automatic test_idle_ticks();
		send_item(i2cbm_pkg::OP_TICK, 8'h00, 1'b0);
		send_item(i2cbm_pkg::OP_TICK, 8'hff, 1'b1);
	endtask

	task automatic test_start_stop();
		run_command(i2cbm_pkg::OP_START, 8'h00, 8'h00, NEVER_LOW);
		run_command(i2cbm_pkg::OP_STOP, 8'h00, 8'h00, NEVER_LOW);
	endtask

	task automatic test_write_byte();
		run_command(i2cbm_pkg::OP_WRITE, 8'hff, 8'h00, NEVER_LOW);
		run_command(i2cbm_pkg::OP_WRITE, 8'h00, 8'h00, NEVER_LOW);
		run_command(i2cbm_pkg::OP_WRITE, 8'ha5, 8'h00, NEVER_LOW);
	endtask

	task automatic test_read_byte();
		run_command(i2cbm_pkg::OP_READ, 8'h00, 8'hff, NEVER_LOW);
		run_command(i2cbm_pkg::OP_READ, 8'h00, 8'h00, NEVER_LOW);
		run_command(i2cbm_pkg::OP_READ, 8'h00, 8'h5a, NEVER_LOW);
	endtask

	task automatic test_ack_nack();
		run_command(i2cbm_pkg::OP_ACK, 8'h00, 8'h00, NEVER_LOW);
		run_command(i2cbm_pkg::OP_NACK, 8'h00, 8'h00, NEVER_LOW);
	endtask

	task automatic test_wait_ack();
		write_ack_timeout(8'd2);
		run_command(i2cbm_pkg::OP_WAIT_ACK, 8'h00, 8'h00, 1);
		run_command(i2cbm_pkg::OP_WAIT_ACK, 8'h00, 8'h00, 3);
		run_command(i2cbm_pkg::OP_WAIT_ACK, 8'h00, 8'h00, NEVER_LOW);
		// error flag clears on the next accepted command
		run_command(i2cbm_pkg::OP_NACK, 8'h00, 8'h00, NEVER_LOW);
	endtask

	task automatic test_timeout_extremes();
		write_ack_timeout(8'd0);
		run_command(i2cbm_pkg::OP_WAIT_ACK, 8'h00, 8'h00, NEVER_LOW);
		run_command(i2cbm_pkg::OP_WAIT_ACK, 8'h00, 8'h00, 1);
		write_ack_timeout(8'd255);
		run_command(i2cbm_pkg::OP_WAIT_ACK, 8'h00, 8'h00, NEVER_LOW);
		run_command(i2cbm_pkg::OP_WAIT_ACK, 8'h00, 8'h00, 256);
		write_ack_timeout(i2cbm_pkg::ACK_TIMEOUT_RST);
	endtask

	task automatic test_busy_commands();
		int k;
		send_item(i2cbm_pkg::OP_WRITE, 8'h3c, 1'b0);
		for (k = 1; k <= 7; k++)
			send_item(3'(k), 8'hc3, 1'(k));
		run_command(i2cbm_pkg::OP_TICK, 8'h00, 8'h00, NEVER_LOW);
		while (mdl_cmd != i2cbm_pkg::CMD_IDLE)
			send_item(i2cbm_pkg::OP_TICK, 8'h00, 1'b1);
	endtask

	task automatic test_backpressure();
		hold_requests++;
		run_command(i2cbm_pkg::OP_WRITE, 8'($urandom_range(255)), 8'h00, NEVER_LOW);
		run_command(i2cbm_pkg::OP_READ, 8'h00, 8'($urandom_range(255)), NEVER_LOW);
		run_command(i2cbm_pkg::OP_START, 8'h00, 8'h00, NEVER_LOW);
	endtask

	task automatic test_drain_pause();
		run_command(i2cbm_pkg::OP_ACK, 8'h00, 8'h00, NEVER_LOW);
		wait_results_drained();
		run_command(i2cbm_pkg::OP_STOP, 8'h00, 8'h00, NEVER_LOW);
	endtask

	task automatic test_random_traffic(input logic [7:0] timeout, input int idle_pct);
		int         target;
		int         low_at;
		logic [2:0] op;
		write_ack_timeout(timeout);
		src_idle_pct = idle_pct;
		rsp_idle_pct = idle_pct;
		noise_pct = 5;
		target = live_items + PHASE_ITEMS;
		while (live_items < target) begin
			if ($urandom_range(9) == 0)
				send_item(i2cbm_pkg::OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
			op = 3'($urandom_range(1, 7));
			case ($urandom_range(3))
				0: low_at = NEVER_LOW;
				1: low_at = int'(mdl_timeout) + 1 + int'($urandom_range(1));
				default: low_at = int'($urandom_range(1, 4));
			endcase
			run_command(op, 8'($urandom_range(255)), 8'($urandom_range(255)), low_at);
		end
		noise_pct = 0;
		src_idle_pct = 27;
		rsp_idle_pct = 27;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.operation = i2cbm_pkg::OP_TICK;
		cmd_bus.write_data = 8'd0;
		cmd_bus.sda_in = 1'b0;
		res_bus.ready = 1'b0;
		errors = 0;
		live_items = 0;
		cycle_count = 0;
		src_idle_pct = 27;
		rsp_idle_pct = 27;
		noise_pct = 0;
		hold_requests = 0;
		holds_served = 0;
		hold_left = 0;
		mdl_cmd = i2cbm_pkg::CMD_IDLE;
		mdl_phase = 3'd0;
		mdl_bits = 4'd0;
		mdl_shift = 8'd0;
		mdl_wait = 8'd0;
		mdl_scl = 1'b1;
		mdl_sda = 1'b1;
		mdl_err = 1'b0;
		mdl_read = 8'd0;
		mdl_timeout = i2cbm_pkg::ACK_TIMEOUT_RST;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ticks();
		test_start_stop();
		test_write_byte();
		test_read_byte();
		test_ack_nack();
		test_busy_commands();
		test_wait_ack();
		test_timeout_extremes();
		test_backpressure();
		test_drain_pause();

		test_random_traffic(8'd3, 27);
		test_random_traffic(8'd0, 0);
		test_random_traffic(8'd1, 27);
		test_random_traffic(8'd255, 27);
		test_random_traffic(8'($urandom_range(255)), 27);
		test_random_traffic(i2cbm_pkg::ACK_TIMEOUT_RST, 27);

		cmd_bus.valid <= 1'b0;
		wait_results_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
